// ===== rtl/salc_pkg.sv =====
// ----------------------------------------------------------------------------
// salc_pkg
// Shared widths, codes and result type of the set-associative cache tag block.
// ----------------------------------------------------------------------------
package salc_pkg;

    // width of a memory block number
    localparam int BLK_W = 30;

    // access kinds
    localparam logic FUNC_WRITE = 1'b1;

    // result actions
    localparam logic ACT_LOAD      = 1'b0;
    localparam logic ACT_WRITEBACK = 1'b1;

    // one result word
    typedef struct packed {
        logic             action;
        logic [BLK_W-1:0] target_block;
        logic             last;
    } t_result;

endpackage

// ===== rtl/salc_req_if.sv =====
// ----------------------------------------------------------------------------
// salc_req_if
// Access request channel: valid/ready handshake with access kind and block.
// ----------------------------------------------------------------------------
interface salc_req_if import salc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             func;
    logic [BLK_W-1:0] block_address;

    modport source (output valid, output func, output block_address, input ready);
    modport sink   (input valid, input func, input block_address, output ready);

endinterface

// ===== rtl/salc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// salc_rsp_if
// Memory action channel: valid/ready handshake with action, block and last.
// ----------------------------------------------------------------------------
interface salc_rsp_if import salc_pkg::*; ();

    logic             valid;
    logic             ready;
    logic             action;
    logic [BLK_W-1:0] target_block;
    logic             last;

    modport source (output valid, output action, output target_block, output last,
                    input ready);
    modport sink   (input valid, input action, input target_block, input last,
                    output ready);

endinterface

// ===== rtl/salc_ram.sv =====
// ----------------------------------------------------------------------------
// salc_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                       i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/set_assoc_lru_writeback_cache_top.sv =====
// ----------------------------------------------------------------------------
// set_assoc_lru_writeback_cache_top
// Tag side of a set-associative write-back, write-allocate cache with LRU.
// ----------------------------------------------------------------------------
// Each request word is a read or write of a block number. The set is
// (block / WAYS) mod SETS. Hits emit nothing; a miss emits a load word, led
// by a write-back word when a dirty LRU line is evicted. A request passes
// through these steps when nothing stalls: the accepting cycle, S_DIV and
// S_MOD run the reciprocal multiplies that form the set index, S_READ reads
// the set row from the tag and state RAMs, S_UPD updates and writes it back.
// Result words are registered by the update. The update waits while
// earlier result words are still queued; the next request is accepted the
// cycle after the update is done. After reset a clearing pass over all SETS
// rows wipes the valid/dirty/age RAM before the first request is taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_writeback_cache_top import salc_pkg::*; #(
    parameter int WAYS = 4,
    parameter int SETS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    salc_req_if.sink    i_req,
    salc_rsp_if.source  o_rsp
);

    // widths
    localparam int AW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int LIM_W   = AW + 1;
    localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int M_W     = BLK_W + 1;
    localparam int PROD_W  = BLK_W + M_W;
    localparam int SETS_W  = $clog2(SETS + 1);
    localparam int PROD3_W = BLK_W + SETS_W;

    // exact reciprocals: floor(x/d) = (x * ceil(2^S/d)) >> S, S = BLK_W + clog2(d)
    localparam int L1 = (WAYS > 1) ? $clog2(WAYS) : 0;
    localparam int S1 = BLK_W + L1;
    localparam logic [63:0] M1_FULL = ((64'd1 << S1) + 64'(WAYS) - 64'd1) / 64'(WAYS);
    localparam logic [M_W-1:0] M1 = M1_FULL[M_W-1:0];
    localparam int L2 = (SETS > 1) ? $clog2(SETS) : 0;
    localparam int S2 = BLK_W + L2;
    localparam logic [63:0] M2_FULL = ((64'd1 << S2) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [M_W-1:0] M2 = M2_FULL[M_W-1:0];

    localparam logic [AW-1:0] AGE_MAX = AW'(WAYS - 1);

    // per-way line state
    typedef struct packed {
        logic          valid;
        logic          dirty;
        logic [AW-1:0] age;
    } t_meta;
    typedef t_meta [WAYS-1:0]            t_meta_row;
    typedef logic  [WAYS-1:0][BLK_W-1:0] t_tag_row;

    localparam int META_W = $bits(t_meta_row);
    localparam int TAG_W  = $bits(t_tag_row);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_DIV   = 6'b000100,
        S_MOD   = 6'b001000,
        S_READ  = 6'b010000,
        S_UPD   = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    logic [SW-1:0]      r_clr;
    logic               r_func;
    logic [BLK_W-1:0]   r_blk;
    logic [PROD_W-1:0]  r_prod1, r_prod2;
    logic [BLK_W-1:0]   r_q;
    logic [BLK_W-1:0]   r_prod3;
    logic [SW-1:0]      r_set;
    t_result            r_res [2];
    logic [1:0]         r_cnt;

    logic               req_fire, rsp_fire, upd_go, clr_done;
    logic [SW-1:0]      set_idx;
    logic [BLK_W-1:0]   q_div, q_mod;

    logic [META_W-1:0]  meta_rd_data, meta_wr_data;
    logic [TAG_W-1:0]   tag_rd_data;
    logic [SW-1:0]      meta_wr_addr;
    logic               meta_wr_en;
    t_meta_row          meta_q, meta_new;
    t_tag_row           tag_q, tag_new;

    logic [WAYS-1:0]    hit_vec, free_vec, vic_vec;
    logic [WAYS-1:0]    hit_oh, free_oh, vic_oh, slot_oh;
    logic               is_hit, any_free, wb_need;
    logic [AW-1:0]      hit_age, vic_age;
    logic [LIM_W-1:0]   limit;
    logic [BLK_W-1:0]   vic_blk;
    logic [WAYS-1:0]    dirty_vec;

    // handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign o_rsp.valid = (r_cnt != 2'd0);
    assign rsp_fire    = o_rsp.valid && o_rsp.ready;
    assign upd_go      = (r_state == S_UPD) && (r_cnt == 2'd0);
    assign clr_done    = (r_clr == SW'(SETS - 1));

    // output word
    assign o_rsp.action       = r_res[0].action;
    assign o_rsp.target_block = r_res[0].target_block;
    assign o_rsp.last         = r_res[0].last;

    // set index arithmetic
    assign q_div   = BLK_W'(r_prod1 >> S1);
    assign q_mod   = BLK_W'(r_prod2 >> S2);
    assign set_idx = SW'(r_q - r_prod3);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (clr_done) n_state = S_IDLE;
            S_IDLE:  if (req_fire) n_state = S_DIV;
            S_DIV:   n_state = S_MOD;
            S_MOD:   n_state = S_READ;
            S_READ:  n_state = S_UPD;
            S_UPD:   if (upd_go) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + SW'(1);
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (req_fire) begin
            r_func  <= i_req.func;
            r_blk   <= i_req.block_address;
            r_prod1 <= PROD_W'(i_req.block_address) * PROD_W'(M1);
        end
        if (r_state == S_DIV) begin
            r_q     <= q_div;
            r_prod2 <= PROD_W'(q_div) * PROD_W'(M2);
        end
        if (r_state == S_MOD) begin
            r_prod3 <= BLK_W'(PROD3_W'(q_mod) * PROD3_W'(SETS));
        end
        if (r_state == S_READ) begin
            r_set <= set_idx;
        end
    end

    // line state RAM: cleared by the pass after reset
    assign meta_wr_en   = (r_state == S_CLEAR) || upd_go;
    assign meta_wr_addr = (r_state == S_CLEAR) ? r_clr : r_set;
    assign meta_wr_data = (r_state == S_CLEAR) ? '0 : META_W'(meta_new);

    salc_ram #(
        .WIDTH (META_W),
        .DEPTH (SETS)
    ) u_meta_ram (
        .i_clk     (i_clk),
        .i_wr_en   (meta_wr_en),
        .i_wr_addr (meta_wr_addr),
        .i_wr_data (meta_wr_data),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (set_idx),
        .o_rd_data (meta_rd_data)
    );

    // block number RAM
    salc_ram #(
        .WIDTH (TAG_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (upd_go),
        .i_wr_addr (r_set),
        .i_wr_data (TAG_W'(tag_new)),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (set_idx),
        .o_rd_data (tag_rd_data)
    );

    assign meta_q = t_meta_row'(meta_rd_data);
    assign tag_q  = t_tag_row'(tag_rd_data);

    // per-way match, free and victim flags
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            hit_vec[w]   = meta_q[w].valid && (tag_q[w] == r_blk);
            free_vec[w]  = !meta_q[w].valid;
            vic_vec[w]   = meta_q[w].valid && (meta_q[w].age == AGE_MAX);
            dirty_vec[w] = meta_q[w].dirty;
        end
    end

    // lowest set bit of each flag vector
    assign hit_oh   = hit_vec & (~hit_vec + WAYS'(1));
    assign free_oh  = free_vec & (~free_vec + WAYS'(1));
    assign vic_oh   = (vic_vec != '0) ? (vic_vec & (~vic_vec + WAYS'(1))) : WAYS'(1);
    assign is_hit   = (hit_vec != '0);
    assign any_free = (free_vec != '0);
    assign slot_oh  = is_hit ? hit_oh : (any_free ? free_oh : vic_oh);
    assign wb_need  = !is_hit && !any_free && ((vic_oh & dirty_vec) != '0);

    // selected ages and victim block
    always_comb begin
        hit_age = '0;
        vic_age = '0;
        vic_blk = '0;
        for (int w = 0; w < WAYS; w++) begin
            hit_age = hit_age | (hit_oh[w] ? meta_q[w].age : '0);
            vic_age = vic_age | (vic_oh[w] ? meta_q[w].age : '0);
            vic_blk = vic_blk | (vic_oh[w] ? tag_q[w] : '0);
        end
    end

    // ways younger than the limit age by one
    always_comb begin
        if (is_hit) begin
            limit = {1'b0, hit_age};
        end else if (any_free) begin
            limit = LIM_W'(WAYS);
        end else begin
            limit = {1'b0, vic_age};
        end
    end

    // new set row
    always_comb begin
        meta_new = meta_q;
        tag_new  = tag_q;
        for (int w = 0; w < WAYS; w++) begin
            if (meta_q[w].valid && ({1'b0, meta_q[w].age} < limit)
                    && (meta_q[w].age < AGE_MAX)) begin
                meta_new[w].age = meta_q[w].age + AW'(1);
            end
            if (slot_oh[w]) begin
                meta_new[w].age = '0;
                if (is_hit) begin
                    meta_new[w].dirty = meta_q[w].dirty || (r_func == FUNC_WRITE);
                end else begin
                    meta_new[w].valid = 1'b1;
                    meta_new[w].dirty = (r_func == FUNC_WRITE);
                    tag_new[w]        = r_blk;
                end
            end
        end
    end

    // two-deep result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (upd_go) begin
            r_cnt <= is_hit ? 2'd0 : (wb_need ? 2'd2 : 2'd1);
        end else if (rsp_fire) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            if (wb_need) begin
                r_res[0] <= '{action: ACT_WRITEBACK, target_block: vic_blk, last: 1'b0};
                r_res[1] <= '{action: ACT_LOAD, target_block: r_blk, last: 1'b1};
            end else begin
                r_res[0] <= '{action: ACT_LOAD, target_block: r_blk, last: 1'b1};
            end
        end else if (rsp_fire) begin
            r_res[0] <= r_res[1];
        end
    end

endmodule

// ===== tb/tb_set_assoc_lru_writeback_cache_top.sv =====
// ----------------------------------------------------------------------------
// tb_set_assoc_lru_writeback_cache_top
// Self-checking bench for the set-associative LRU write-back cache tag block.
// ----------------------------------------------------------------------------
// A directed table covers first fills, read and write hits, clean and dirty
// evictions and the extremes of the block number. Random traffic follows,
// mostly aimed at a few hot sets and tags so that sets fill, hit and evict.
// A tag-side model tracks every set and predicts the memory action words of
// each accepted access whose table row gives no fixed expectation. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_writeback_cache_top;
    import salc_pkg::*;

    localparam int CACHE_WAYS   = 4;
    localparam int CACHE_SETS   = 64;
    localparam int LINES        = CACHE_WAYS * CACHE_SETS;
    localparam int AGE_W        = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
    localparam int TAG_MAX      = (2 ** BLK_W) / LINES - 1;
    localparam int HOT_TAGS     = 7;
    localparam int HOT_SETS     = 4;
    localparam int RAND_WORDS   = 550;
    localparam int DRAIN_CYCLES = 20;
    localparam int DIR_ROWS     = 21;

    localparam logic FUNC_READ = ~FUNC_WRITE;

    // how a table row is checked
    typedef enum logic [1:0] {
        ROW_PRED,   // expectation from the tag model
        ROW_HIT,    // no action word
        ROW_LOAD    // one load word of the accessed block
    } t_row_kind;

    typedef struct {
        logic             func;
        logic [BLK_W-1:0] blk;
        t_row_kind        kind;
    } t_row;

    // set 0 holds 0..3 and every multiple of 256; 0x3FFFFFFC..0x3FFFFFFF sit in set 63
    t_row dir_rows [DIR_ROWS] = '{
        '{FUNC_READ,  30'h0000_0000, ROW_LOAD},
        '{FUNC_WRITE, 30'h3FFF_FFFF, ROW_LOAD},
        '{FUNC_READ,  30'h0000_0000, ROW_HIT},
        '{FUNC_WRITE, 30'h0000_0000, ROW_HIT},
        '{FUNC_READ,  30'h0000_0001, ROW_LOAD},
        '{FUNC_READ,  30'h0000_0100, ROW_LOAD},
        '{FUNC_WRITE, 30'h2AAA_AA02, ROW_LOAD},
        '{FUNC_READ,  30'h1555_5500, ROW_PRED},
        '{FUNC_READ,  30'h0000_0001, ROW_HIT},
        '{FUNC_WRITE, 30'h0000_0300, ROW_PRED},
        '{FUNC_WRITE, 30'h2AAA_AA02, ROW_HIT},
        '{FUNC_READ,  30'h3FFF_FF00, ROW_PRED},
        '{FUNC_READ,  30'h3FFF_FFFF, ROW_HIT},
        '{FUNC_WRITE, 30'h3FFF_FFFC, ROW_LOAD},
        '{FUNC_READ,  30'h2AAA_AAAA, ROW_LOAD},
        '{FUNC_WRITE, 30'h1555_5555, ROW_LOAD},
        '{FUNC_WRITE, 30'h0000_0400, ROW_PRED},
        '{FUNC_WRITE, 30'h0000_0500, ROW_PRED},
        '{FUNC_WRITE, 30'h0000_0600, ROW_PRED},
        '{FUNC_READ,  30'h0000_0700, ROW_PRED},
        '{FUNC_READ,  30'h0000_0400, ROW_PRED}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    salc_req_if req_if ();
    salc_rsp_if rsp_if ();

    set_assoc_lru_writeback_cache_top #(
        .WAYS (CACHE_WAYS),
        .SETS (CACHE_SETS)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // tag model state, line index = set * WAYS + way
    logic             line_valid [LINES];
    logic [BLK_W-1:0] line_blk   [LINES];
    logic             line_dirty [LINES];
    logic [AGE_W-1:0] line_age   [LINES];

    t_result     mem_ops_due [$];
    t_row_kind   row_kinds   [$];
    int          mismatches = 0;
    bit          req_calm   = 1'b0;
    bit          rsp_calm   = 1'b0;
    int unsigned hot_tag [HOT_TAGS];
    int unsigned hot_set [HOT_SETS];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // age every valid way of the set that is younger than limit and not yet at the oldest age
    function automatic void age_ways(input int base, input int limit);
        for (int w = 0; w < CACHE_WAYS; w++) begin
            if (line_valid[base+w] && int'(line_age[base+w]) < limit &&
                int'(line_age[base+w]) < CACHE_WAYS - 1)
                line_age[base+w] = line_age[base+w] + 1'b1;
        end
    endfunction

    // update the tag model for one access; queue its action words when keep
    function automatic void track_access(input logic wr, input logic [BLK_W-1:0] blk,
                                         input bit keep);
        int      base;
        int      slot;
        bit      hit;
        bit      free;
        t_result word;
        base = int'((blk / CACHE_WAYS) % CACHE_SETS) * CACHE_WAYS;
        hit  = 1'b0;
        free = 1'b0;
        slot = base;
        for (int w = 0; w < CACHE_WAYS; w++) begin
            if (!hit && line_valid[base+w] && line_blk[base+w] == blk) begin
                hit  = 1'b1;
                slot = base + w;
            end
        end
        // hit: refresh LRU order, write marks dirty, no word
        if (hit) begin
            age_ways(base, int'(line_age[slot]));
            line_age[slot] = '0;
            if (wr == FUNC_WRITE)
                line_dirty[slot] = 1'b1;
            return;
        end
        for (int w = 0; w < CACHE_WAYS; w++) begin
            if (!free && !line_valid[base+w]) begin
                free = 1'b1;
                slot = base + w;
            end
        end
        if (free) begin
            age_ways(base, CACHE_WAYS);
        end else begin
            // oldest way is the victim, lowest way on a tie
            slot = base;
            for (int w = 1; w < CACHE_WAYS; w++) begin
                if (line_age[base+w] > line_age[slot])
                    slot = base + w;
            end
            if (line_dirty[slot] && keep) begin
                word.action       = ACT_WRITEBACK;
                word.target_block = line_blk[slot];
                word.last         = 1'b0;
                mem_ops_due.push_back(word);
            end
            age_ways(base, int'(line_age[slot]));
        end
        line_valid[slot] = 1'b1;
        line_blk[slot]   = blk;
        line_dirty[slot] = (wr == FUNC_WRITE);
        line_age[slot]   = '0;
        if (keep) begin
            word.action       = ACT_LOAD;
            word.target_block = blk;
            word.last         = 1'b1;
            mem_ops_due.push_back(word);
        end
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // present one request word and hold it until accepted
    task automatic send_word(input logic f, input logic [BLK_W-1:0] b);
        int gap;
        gap = pick_gap(req_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.func          <= f;
        req_if.block_address <= b;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // accepted requests feed the model, accepted words are checked
    always @(posedge i_clk) begin
        t_row_kind kind;
        t_result   want;
        t_result   load;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                kind = (row_kinds.size() != 0) ? row_kinds.pop_front() : ROW_PRED;
                track_access(req_if.func, req_if.block_address, kind == ROW_PRED);
                if (kind == ROW_LOAD) begin
                    load.action       = ACT_LOAD;
                    load.target_block = req_if.block_address;
                    load.last         = 1'b1;
                    mem_ops_due.push_back(load);
                end
            end
            if (rsp_if.valid && rsp_if.ready) begin
                if (mem_ops_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word: expected none, actual %0b/%h/%0b",
                             $time, rsp_if.action, rsp_if.target_block, rsp_if.last);
                end else begin
                    want = mem_ops_due.pop_front();
                    if (rsp_if.action !== want.action) begin
                        mismatches++;
                        $display("%0t: action: expected %0b, actual %0b",
                                 $time, want.action, rsp_if.action);
                    end
                    if (rsp_if.target_block !== want.target_block) begin
                        mismatches++;
                        $display("%0t: target_block: expected %h, actual %h",
                                 $time, want.target_block, rsp_if.target_block);
                    end
                    if (rsp_if.last !== want.last) begin
                        mismatches++;
                        $display("%0t: last: expected %0b, actual %0b",
                                 $time, want.last, rsp_if.last);
                    end
                end
            end
        end
    end

    // receiver: ready runs broken by random stalls
    initial begin
        int gap;
        rsp_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            if ($urandom_range(0, 9) == 0)
                rsp_calm = !rsp_calm;
            gap = pick_gap(rsp_calm);
            if (gap > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // stimulus and end of run
    initial begin
        logic             f;
        logic [BLK_W-1:0] b;
        int unsigned      raw;
        for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_blk[i]   = '0;
            line_dirty[i] = 1'b0;
            line_age[i]   = '0;
        end
        hot_tag[0] = 0;
        hot_tag[1] = TAG_MAX;
        for (int i = 2; i < HOT_TAGS; i++)
            hot_tag[i] = $urandom_range(0, TAG_MAX);
        hot_set[0] = 0;
        hot_set[1] = CACHE_SETS - 1;
        for (int i = 2; i < HOT_SETS; i++)
            hot_set[i] = $urandom_range(0, CACHE_SETS - 1);

        i_rst_n              <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.func          <= FUNC_READ;
        req_if.block_address <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            row_kinds.push_back(dir_rows[r].kind);
            send_word(dir_rows[r].func, dir_rows[r].blk);
        end

        // random traffic, mostly hot sets and tags to force hits and evictions
        for (int n = 0; n < RAND_WORDS; n++) begin
            if ($urandom_range(0, 39) == 0)
                req_calm = !req_calm;
            f = logic'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 15) begin
                b = BLK_W'($urandom);
            end else begin
                raw = hot_tag[$urandom_range(0, HOT_TAGS - 1)] * LINES
                    + hot_set[$urandom_range(0, HOT_SETS - 1)] * CACHE_WAYS
                    + $urandom_range(0, CACHE_WAYS - 1);
                b = BLK_W'(raw);
            end
            row_kinds.push_back(ROW_PRED);
            send_word(f, b);
        end
        req_if.valid <= 1'b0;

        // wait so the last accepted access is in the model
        @(posedge i_clk);
        while (mem_ops_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
